// ===== src/satd_pkg.sv =====
`timescale 1ns / 1ps

package satd_pkg;

  // Pixel and row geometry.
  localparam int PIX_W    = 8;
  localparam int WORD_PIX = 8;
  localparam int LANE_PIX = 4;
  localparam int BUF_ROWS = 3;

  // Coefficient widths: row transform, full 13-bit arithmetic, absolute value.
  localparam int ROW_W  = 11;
  localparam int HC_W   = 13;
  localparam int ABS_W  = 12;
  localparam int BLK_W  = 16;
  localparam int HALF_W = 15;
  localparam int OUT_W  = 32;

  typedef logic [1:0] phase_t;

  // Phase of the fourth row of a tile.
  localparam phase_t PHASE_LAST = 2'd3;

  typedef logic signed [ROW_W-1:0] rc_t;
  typedef logic signed [HC_W-1:0]  hc_t;
  typedef hc_t                     hvec_t [LANE_PIX];

  // Per-lane pipeline control.
  typedef struct packed {
    logic   ld1;
    logic   ld2;
    logic   ld3;
    logic   buf_we;
    phase_t buf_sel;
  } lane_ctrl_t;

  // Merge and accumulate control.
  typedef struct packed {
    logic ld4;
    logic done3;
    logic acc_en;
    logic last4;
  } merge_ctrl_t;

  // Four-point Hadamard butterfly.
  function automatic hvec_t hadamard4(hvec_t x);
    hc_t   s0;
    hc_t   d0;
    hc_t   s1;
    hc_t   d1;
    hvec_t y;
    s0   = x[0] + x[1];
    d0   = x[0] - x[1];
    s1   = x[2] + x[3];
    d1   = x[2] - x[3];
    y[0] = s0 + s1;
    y[1] = d0 + d1;
    y[2] = s0 - s1;
    y[3] = d0 - d1;
    return y;
  endfunction

endpackage

// ===== src/satd_lane.sv =====
`timescale 1ns / 1ps

module satd_lane (
  input  logic                                clk,
  input  logic [satd_pkg::LANE_PIX*satd_pkg::PIX_W-1:0] cur_pix,
  input  logic [satd_pkg::LANE_PIX*satd_pkg::PIX_W-1:0] ref_pix,
  input  satd_pkg::lane_ctrl_t                ctrl,
  output logic [satd_pkg::HALF_W-1:0]         half_sum
);

  localparam int NP = satd_pkg::LANE_PIX;

  satd_pkg::rc_t              row_tr   [NP];
  satd_pkg::rc_t              row_buf  [satd_pkg::BUF_ROWS][NP];
  logic [satd_pkg::ABS_W-1:0] abs_coef [NP*NP];
  logic [satd_pkg::HALF_W-1:0] half_reg;

  satd_pkg::hvec_t            diff;
  satd_pkg::hvec_t            row_h;
  logic [satd_pkg::ABS_W-1:0] abs_next [NP*NP];
  logic [satd_pkg::BLK_W-1:0] blk_sum;

  // Pixel differences and the horizontal transform.
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      diff[i] = satd_pkg::hc_t'({1'b0, cur_pix[i*satd_pkg::PIX_W +: satd_pkg::PIX_W]})
              - satd_pkg::hc_t'({1'b0, ref_pix[i*satd_pkg::PIX_W +: satd_pkg::PIX_W]});
    end
    row_h = satd_pkg::hadamard4(diff);
  end

  // First stage holds the row transform of the accepted beat.
  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      for (int i = 0; i < NP; i++) begin
        row_tr[i] <= row_h[i][satd_pkg::ROW_W-1:0];
      end
    end
  end

  // Row buffer for the first three rows of a tile.
  always_ff @(posedge clk) begin
    if (ctrl.buf_we) begin
      for (int i = 0; i < NP; i++) begin
        row_buf[ctrl.buf_sel][i] <= row_tr[i];
      end
    end
  end

  // Vertical transform down each column and absolute values.
  always_comb begin
    satd_pkg::hvec_t col_in;
    satd_pkg::hvec_t col_out;
    for (int c = 0; c < NP; c++) begin
      for (int r = 0; r < satd_pkg::BUF_ROWS; r++) begin
        col_in[r] = satd_pkg::hc_t'(row_buf[r][c]);
      end
      col_in[NP-1] = satd_pkg::hc_t'(row_tr[c]);
      col_out = satd_pkg::hadamard4(col_in);
      for (int i = 0; i < NP; i++) begin
        if (col_out[i] < 0) begin
          abs_next[c*NP+i] = satd_pkg::ABS_W'(-col_out[i]);
        end else begin
          abs_next[c*NP+i] = satd_pkg::ABS_W'(col_out[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      abs_coef <= abs_next;
    end
  end

  // Block sum of the sixteen magnitudes, halved.
  always_comb begin
    blk_sum = '0;
    for (int k = 0; k < NP*NP; k++) begin
      blk_sum = blk_sum + satd_pkg::BLK_W'(abs_coef[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld3) begin
      half_reg <= blk_sum[satd_pkg::BLK_W-1:1];
    end
  end

  assign half_sum = half_reg;

endmodule

// ===== src/satd_merge.sv =====
`timescale 1ns / 1ps

module satd_merge #(
  parameter int LANES     = 2,
  parameter int SUM_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [satd_pkg::HALF_W-1:0]   lane_sum [LANES],
  input  satd_pkg::merge_ctrl_t         ctrl,
  output logic [satd_pkg::OUT_W-1:0]    total
);

  localparam int MW    = satd_pkg::HALF_W + $clog2(LANES);
  localparam int CMP_W = (SUM_WIDTH > satd_pkg::OUT_W) ? SUM_WIDTH : satd_pkg::OUT_W;

  logic [MW-1:0]              tile_sum;
  logic [SUM_WIDTH-1:0]       running_sum;
  logic [satd_pkg::OUT_W-1:0] total_reg;

  logic [MW-1:0]              lanes_add;
  logic [SUM_WIDTH:0]         sum_wide;
  logic [SUM_WIDTH-1:0]       sum_next;
  logic [CMP_W-1:0]           sum_ext;
  logic [satd_pkg::OUT_W-1:0] total_next;

  // Add the lane results of one finished tile.
  always_comb begin
    lanes_add = '0;
    for (int b = 0; b < LANES; b++) begin
      lanes_add = lanes_add + MW'(lane_sum[b]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld4) begin
      tile_sum <= ctrl.done3 ? lanes_add : '0;
    end
  end

  // Saturating accumulate and clamp of the reported total.
  always_comb begin
    sum_wide = {1'b0, running_sum} + (SUM_WIDTH+1)'(tile_sum);
    sum_next = sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
    sum_ext  = CMP_W'(sum_next);
    if (sum_ext > CMP_W'({satd_pkg::OUT_W{1'b1}})) begin
      total_next = '1;
    end else begin
      total_next = sum_ext[satd_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (ctrl.acc_en) begin
      running_sum <= ctrl.last4 ? '0 : sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_en && ctrl.last4) begin
      total_reg <= total_next;
    end
  end

  assign total = total_reg;

endmodule

// ===== src/satd_hadamard_4x4_sum_core.sv =====
`timescale 1ns / 1ps

// SATD over 4x4 Hadamard blocks. Each input beat carries one pixel row of LANES
// side-by-side 4x4 blocks; four beats make a tile, top row first. The block is
// fully pipelined: it takes one beat per clock with no gaps while the output
// register does not stall, and a result beat reaches the output register after
// the beat flagged tlast is accepted (row transform at acceptance, then column
// transform, block sum, lane merge and accumulate).
// The only stall comes from the output register: a beat flagged tlast that
// reaches the accumulator while the previous total has not been taken holds the
// pipeline until m_axis_tready. The running sum saturates at 2^SUM_WIDTH - 1
// and the reported total at 2^32 - 1. A tlast beat also ends the current tile.
module satd_hadamard_4x4_sum_core #(
  parameter int LANES     = 2,
  parameter int SUM_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // [63:0] cur_row, [127:64] ref_row
  input  logic         s_axis_tlast,  // last_item
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata   // [31:0] satd_total
);

  localparam int WORD_W = satd_pkg::WORD_PIX * satd_pkg::PIX_W;
  localparam int LW     = satd_pkg::LANE_PIX * satd_pkg::PIX_W;

  logic [WORD_W-1:0] cur_row;
  logic [WORD_W-1:0] ref_row;

  satd_pkg::phase_t phase;
  satd_pkg::phase_t ph1;
  logic v1, v2, v3, v4, out_v;
  logic last1, last2, last3, last4;
  logic done2, done3;

  logic adv1, adv2, adv3, adv4, adv5;
  logic rdy1, rdy2, rdy3, rdy4;

  satd_pkg::lane_ctrl_t       lane_ctrl;
  satd_pkg::merge_ctrl_t      merge_ctrl;
  logic [satd_pkg::HALF_W-1:0] lane_sum [LANES];

  assign cur_row = s_axis_tdata[WORD_W-1:0];
  assign ref_row = s_axis_tdata[2*WORD_W-1:WORD_W];

  // Ready chain: each stage moves when the one after it has room.
  always_comb begin
    adv5 = v4 && (!last4 || !out_v || m_axis_tready);
    rdy4 = !v4 || adv5;
    adv4 = v3 && rdy4;
    rdy3 = !v3 || adv4;
    adv3 = v2 && rdy3;
    rdy2 = !v2 || adv3;
    adv2 = v1 && rdy2;
    rdy1 = !v1 || adv2;
    adv1 = s_axis_tvalid && rdy1;
  end

  assign s_axis_tready = rdy1;

  // Row phase within the tile; tlast starts a fresh tile.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (adv1) begin
      if (s_axis_tlast || phase == satd_pkg::PHASE_LAST) begin
        phase <= '0;
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      out_v <= 1'b0;
    end else begin
      v1 <= adv1 ? 1'b1 : (adv2 ? 1'b0 : v1);
      v2 <= adv2 ? 1'b1 : (adv3 ? 1'b0 : v2);
      v3 <= adv3 ? 1'b1 : (adv4 ? 1'b0 : v3);
      v4 <= adv4 ? 1'b1 : (adv5 ? 1'b0 : v4);
      if (adv5 && last4) begin
        out_v <= 1'b1;
      end else if (m_axis_tready) begin
        out_v <= 1'b0;
      end
    end
  end

  // Tags that travel with each beat.
  always_ff @(posedge clk) begin
    if (adv1) begin
      ph1   <= phase;
      last1 <= s_axis_tlast;
    end
    if (adv2) begin
      done2 <= (ph1 == satd_pkg::PHASE_LAST);
      last2 <= last1;
    end
    if (adv3) begin
      done3 <= done2;
      last3 <= last2;
    end
    if (adv4) begin
      last4 <= last3;
    end
  end

  always_comb begin
    lane_ctrl.ld1     = adv1;
    lane_ctrl.ld2     = adv2;
    lane_ctrl.ld3     = adv3;
    lane_ctrl.buf_we  = adv2 && (ph1 != satd_pkg::PHASE_LAST);
    lane_ctrl.buf_sel = ph1;
    merge_ctrl.ld4    = adv4;
    merge_ctrl.done3  = done3;
    merge_ctrl.acc_en = adv5;
    merge_ctrl.last4  = last4;
  end

  // Lanes; pixels past the row word read as zero.
  for (genvar b = 0; b < LANES; b++) begin : g_lane
    logic [LW-1:0] cur_pix;
    logic [LW-1:0] ref_pix;
    if ((b + 1) * satd_pkg::LANE_PIX <= satd_pkg::WORD_PIX) begin : g_in
      assign cur_pix = cur_row[b*LW +: LW];
      assign ref_pix = ref_row[b*LW +: LW];
    end else begin : g_zero
      assign cur_pix = '0;
      assign ref_pix = '0;
    end

    satd_lane u_lane (
      .clk      (clk),
      .cur_pix  (cur_pix),
      .ref_pix  (ref_pix),
      .ctrl     (lane_ctrl),
      .half_sum (lane_sum[b])
    );
  end

  satd_merge #(
    .LANES     (LANES),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .lane_sum (lane_sum),
    .ctrl     (merge_ctrl),
    .total    (m_axis_tdata)
  );

  assign m_axis_tvalid = out_v;

endmodule

// ===== src/satd_checker.sv =====
`timescale 1ns / 1ps

module satd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [31:0]  m_axis_tdata
);

  // A result beat that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result pending after reset");

  // A ready sink never back-pressures the input.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  // No result appears in the cycle right after reset release without input.
  a_no_early: assert property (@(posedge clk)
    $fell(rst) |-> !m_axis_tvalid)
    else $error("result appeared before any beat could finish");

endmodule

bind satd_hadamard_4x4_sum_core satd_checker u_satd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
